### rtl/lens_point_undistort_iterative_unit_macros.svh
// Assertion macros for the point undistortion unit.
// Used by the checker file only.
`ifndef LENS_POINT_UNDISTORT_ITERATIVE_UNIT_MACROS_SVH
`define LENS_POINT_UNDISTORT_ITERATIVE_UNIT_MACROS_SVH
// Implication checked on every clock, off in reset.
`define LPU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked also during reset.
`define LPU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/lpu_pkg.sv
// Package for the point undistortion unit: widths, Q4.28 helpers, register indexes.
// No dependencies.
`timescale 1ns / 1ps
package lpu_pkg;
  localparam int unsigned Iterations = 20;
  localparam int unsigned Frac = 28;
  localparam int unsigned PixW = 16;
  localparam int unsigned FocW = 18;
  localparam int unsigned OutW = 18;
  localparam int unsigned QW = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  // normalization divider: numerator 17+28 bits magnitude, quotient kept 46 bits
  localparam int unsigned DivNumW = 46;

  typedef enum logic [CfgIdxW-1:0] {
    RegFocalX = 3'd0, RegFocalY = 3'd1, RegCenterX = 3'd2, RegCenterY = 3'd3,
    RegK1 = 3'd4, RegK2 = 3'd5, RegP1 = 3'd6, RegP2 = 3'd7
  } reg_idx_e;

  typedef logic signed [QW-1:0] q_t;

  typedef struct packed {
    logic [FocW-1:0] focal_x;
    logic [FocW-1:0] focal_y;
    logic [PixW-1:0] center_x;
    logic [PixW-1:0] center_y;
    q_t k1;
    q_t k2;
    q_t p1;
    q_t p2;
  } cfg_t;

  typedef struct packed {
    q_t mx;
    q_t my;
    q_t x;
    q_t y;
  } iter_t;

  function automatic q_t sat_q(input logic signed [39:0] v);
    if (v > 40'sd2147483647) return 32'sh7fffffff;
    if (v < -40'sd2147483648) return 32'sh80000000;
    return v[QW-1:0];
  endfunction

  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = 64'(a) * 64'(b);
    s = (p + 64'sd134217728) >>> Frac;
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return s[QW-1:0];
  endfunction
endpackage

### rtl/lpu_stream_if.sv
// Valid/ready stream interface with generic payload width.
// Depends on nothing.
`timescale 1ns / 1ps
interface lpu_stream_if #(parameter int unsigned W = 32) ();
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/lpu_norm_div.sv
// Pipelined restoring divider for normalization, one quotient bit per stage.
// Depends on lpu_pkg.
`timescale 1ns / 1ps
module lpu_norm_div (
  input  logic clk_i,
  input  logic en_i,
  input  logic [lpu_pkg::PixW-1:0] p_i,
  input  logic [lpu_pkg::PixW-1:0] c_i,
  input  logic [lpu_pkg::FocW-1:0] f_i,
  output lpu_pkg::q_t q_o
);
  localparam int unsigned N = lpu_pkg::DivNumW;
  localparam int unsigned FW = lpu_pkg::FocW;
  localparam int unsigned PixW_E = lpu_pkg::PixW;
  logic [N-1:0] num_q [N+1];
  logic [FW:0] rem_q [N+1];
  logic [FW-1:0] div_q [N+1];
  logic neg_q [N+1];

  logic signed [PixW_E:0] diff;
  assign diff = $signed({1'b0, p_i}) - $signed({1'b0, c_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0] <= diff[PixW_E];
      num_q[0] <= N'(diff[PixW_E] ? -diff : diff) << lpu_pkg::Frac;
      rem_q[0] <= '0;
      div_q[0] <= (f_i == '0) ? FW'(1) : f_i;
    end
  end

  for (genvar s = 0; s < N; s++) begin : g_st
    logic [FW+1:0] tr;
    assign tr = {rem_q[s], num_q[s][N-1]} - {2'b0, div_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        neg_q[s+1] <= neg_q[s];
        div_q[s+1] <= div_q[s];
        if (!tr[FW+1]) begin
          rem_q[s+1] <= tr[FW:0];
          num_q[s+1] <= {num_q[s][N-2:0], 1'b1};
        end else begin
          rem_q[s+1] <= {rem_q[s][FW-1:0], num_q[s][N-1]};
          num_q[s+1] <= {num_q[s][N-2:0], 1'b0};
        end
      end
    end
  end

  logic signed [N:0] sq;
  assign sq = neg_q[N] ? -$signed({1'b0, num_q[N]}) : $signed({1'b0, num_q[N]});
  assign q_o = (sq > (N+1)'(64'sd2147483647)) ? 32'sh7fffffff :
               (sq < -(N+1)'(64'sd2147483648)) ? 32'sh80000000 : sq[31:0];
endmodule

### rtl/lpu_iter_cell.sv
// One damped fixed-point iteration, split over four register stages.
// Depends on lpu_pkg.
`timescale 1ns / 1ps
module lpu_iter_cell (
  input  logic clk_i,
  input  logic en_i,
  input  lpu_pkg::cfg_t cfg_i,
  input  lpu_pkg::iter_t in_i,
  output lpu_pkg::iter_t out_o
);
  typedef logic signed [39:0] w_t;
  lpu_pkg::iter_t s1_q, s2_q, s3_q;
  lpu_pkg::q_t x2_q, y2_q, xy_q, r4_q, ax_q, ay_q, k1r_q;
  lpu_pkg::q_t rad_q, bx_q, by_q, t1_q, t2_q, cx_q, cy_q;

  // stage 1: squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= in_i;
      x2_q <= lpu_pkg::qmul(in_i.x, in_i.x);
      y2_q <= lpu_pkg::qmul(in_i.y, in_i.y);
      xy_q <= lpu_pkg::qmul(in_i.x, in_i.y);
    end
  end
  lpu_pkg::q_t r2;
  assign r2 = lpu_pkg::sat_q(w_t'(x2_q) + w_t'(y2_q));
  // stage 2: r4, tangential terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_q <= s1_q;
      r4_q <= lpu_pkg::qmul(r2, r2);
      k1r_q <= lpu_pkg::qmul(cfg_i.k1, r2);
      t1_q <= lpu_pkg::qmul(cfg_i.p1, xy_q);
      t2_q <= lpu_pkg::qmul(cfg_i.p2, xy_q);
      ax_q <= lpu_pkg::qmul(cfg_i.p2, lpu_pkg::sat_q(w_t'(r2) + 2 * w_t'(x2_q)));
      ay_q <= lpu_pkg::qmul(cfg_i.p1, lpu_pkg::sat_q(w_t'(r2) + 2 * w_t'(y2_q)));
    end
  end
  lpu_pkg::q_t rad;
  assign rad = lpu_pkg::sat_q(w_t'(64'sd268435456) + w_t'(k1r_q)
                              + w_t'(lpu_pkg::qmul(cfg_i.k2, r4_q)));
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_q <= s2_q;
      rad_q <= rad;
      bx_q <= ax_q;
      by_q <= ay_q;
      cx_q <= t1_q;
      cy_q <= t2_q;
    end
  end
  lpu_pkg::q_t xd, yd;
  assign xd = lpu_pkg::sat_q(w_t'(lpu_pkg::qmul(s3_q.x, rad_q)) + 2 * w_t'(cx_q) + w_t'(bx_q));
  assign yd = lpu_pkg::sat_q(w_t'(lpu_pkg::qmul(s3_q.y, rad_q)) + w_t'(by_q) + 2 * w_t'(cy_q));
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_o.mx <= s3_q.mx;
      out_o.my <= s3_q.my;
      out_o.x <= lpu_pkg::sat_q(w_t'(s3_q.x) + ((w_t'(s3_q.mx) - w_t'(xd)) >>> 1));
      out_o.y <= lpu_pkg::sat_q(w_t'(s3_q.y) + ((w_t'(s3_q.my) - w_t'(yd)) >>> 1));
    end
  end
endmodule

### rtl/lens_point_undistort_iterative_unit.sv
// Top level: config registers, normalization divider, chain of iteration cells, output map.
// Depends on lpu_pkg, lpu_stream_if, lpu_norm_div, lpu_iter_cell.
//  channel | dir | payload
//  in_s    | in  | point_y[31:16] point_x[15:0]
//  out_s   | out | undist_y[35:18] undist_x[17:0]
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
// One point per cycle while the output is not stalled; pipe of 47 divider + 4*ITERATIONS cell + 2 output stages.
// The whole pipe advances when the output slot is empty or taken; it stalls as one.
// Reset clears valid flags and loads register defaults.
`timescale 1ns / 1ps
module lens_point_undistort_iterative_unit #(
  parameter int unsigned ITERATIONS = lpu_pkg::Iterations
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [lpu_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lpu_pkg::CfgDataW-1:0] cfg_data_i,
  lpu_stream_if.sink in_s,
  lpu_stream_if.source out_s
);
  localparam int unsigned Lat = lpu_pkg::DivNumW + 1 + 4 * ITERATIONS + 2;
  lpu_pkg::cfg_t cfg_q;
  logic [Lat-1:0] vld_q;
  logic en;
  assign en = !vld_q[Lat-1] || out_s.ready;
  assign in_s.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{focal_x: 18'd8000, focal_y: 18'd8000, center_x: 16'd5120,
                 center_y: 16'd3840, default: '0};
    end else if (cfg_we_i) begin
      unique case (lpu_pkg::reg_idx_e'(cfg_idx_i))
        lpu_pkg::RegFocalX: cfg_q.focal_x <= cfg_data_i[17:0];
        lpu_pkg::RegFocalY: cfg_q.focal_y <= cfg_data_i[17:0];
        lpu_pkg::RegCenterX: cfg_q.center_x <= cfg_data_i[15:0];
        lpu_pkg::RegCenterY: cfg_q.center_y <= cfg_data_i[15:0];
        lpu_pkg::RegK1: cfg_q.k1 <= cfg_data_i;
        lpu_pkg::RegK2: cfg_q.k2 <= cfg_data_i;
        lpu_pkg::RegP1: cfg_q.p1 <= cfg_data_i;
        default: cfg_q.p2 <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Lat-2:0], in_s.valid};
  end

  lpu_pkg::iter_t chain [ITERATIONS+1];
  lpu_norm_div u_dx (.clk_i, .en_i(en), .p_i(in_s.data[15:0]), .c_i(cfg_q.center_x),
                     .f_i(cfg_q.focal_x), .q_o(chain[0].mx));
  lpu_norm_div u_dy (.clk_i, .en_i(en), .p_i(in_s.data[31:16]), .c_i(cfg_q.center_y),
                     .f_i(cfg_q.focal_y), .q_o(chain[0].my));
  assign chain[0].x = chain[0].mx;
  assign chain[0].y = chain[0].my;

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    lpu_iter_cell u_cell (.clk_i, .en_i(en), .cfg_i(cfg_q), .in_i(chain[i]),
                          .out_o(chain[i+1]));
  end

  logic signed [63:0] px_q, py_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= 64'(chain[ITERATIONS].x) * $signed({46'b0, cfg_q.focal_x});
      py_q <= 64'(chain[ITERATIONS].y) * $signed({46'b0, cfg_q.focal_y});
    end
  end
  function automatic logic [17:0] to_pix(input logic signed [63:0] p, input logic [15:0] c);
    logic signed [63:0] v;
    v = ((p + 64'sd134217728) >>> 28) + $signed({48'b0, c});
    if (v > 64'sd131071) return 18'h1ffff;
    if (v < -64'sd131072) return 18'h20000;
    return v[17:0];
  endfunction
  always_ff @(posedge clk_i) begin
    if (en) out_s.data <= {to_pix(py_q, cfg_q.center_y), to_pix(px_q, cfg_q.center_x)};
  end
  assign out_s.valid = vld_q[Lat-1];
endmodule

### rtl/lpu_checker.sv
// Port-level checker for the undistortion unit, bound to the top level.
// Depends on the macros header.
`timescale 1ns / 1ps
`include "lens_point_undistort_iterative_unit_macros.svh"
module lpu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [35:0] out_data
);
  `LPU_ASSERT(a_hold, clk_i, rst_ni, out_valid && !out_ready |=> out_valid && $stable(out_data), "output transaction dropped")
  `LPU_ASSERT(a_ready, clk_i, rst_ni, !out_valid |-> in_ready, "input stalled while output empty")
  `LPU_ASSERT(a_stall, clk_i, rst_ni, out_valid && !out_ready |-> !in_ready, "input taken during stall")
  `LPU_ASSERT_ALWAYS(a_rst, clk_i, !rst_ni |-> !out_valid, "output valid in reset")
endmodule
bind lens_point_undistort_iterative_unit lpu_checker u_chk (.clk_i, .rst_ni,
  .in_ready(in_s.ready), .out_valid(out_s.valid),
  .out_ready(out_s.ready), .out_data(out_s.data));
